// ----- rtl/cdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter package
// Field widths, opcodes, controller states, the command and status bundles
// between controller and datapath, and the calendar helper functions.
// ----------------------------------------------------------------------------
package cdc_pkg;

	// Field widths of the item channels.
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 16;
	localparam int unsigned COUNT_W  = 20;
	localparam int unsigned XDAYS_W  = 9;
	localparam int unsigned DOY_W    = 9;

	// Default number of day_count bits that are used.
	localparam int unsigned COUNT_BITS_DEFAULT = 20;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_SET  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_CMP  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_XMAS = 3'd4;

	// Calendar constants.
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   LEN_SHORT = 5'd30;
	localparam logic [DAY_W-1:0]   LEN_LONG  = 5'd31;
	localparam logic [DAY_W-1:0]   LEN_FEB   = 5'd28;
	localparam logic [DAY_W-1:0]   LEN_FEB_L = 5'd29;
	localparam logic [DOY_W-1:0]   XMAS_DOY  = 9'd359;
	localparam logic [DOY_W-1:0]   YEAR_DAYS = 9'd365;

	// Reset date: 1 January 2000, a leap year.
	localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
	localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
	localparam logic [YEAR_W-1:0]  RST_YEAR  = 16'd2000;
	localparam logic               RST_LEAP  = 1'b1;

	// Divisibility by 25 through a reciprocal multiply: the top bits of
	// y * 83887 from bit 21 upward equal y / 25 for every 16-bit year.
	localparam int unsigned       QUOT_W      = 12;
	localparam int unsigned       PROD_W      = 33;
	localparam logic [PROD_W-1:0] DIV25_RECIP = 33'd83887;
	localparam logic [YEAR_W-1:0] DIV25       = 16'd25;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LSTART,
		S_LWAIT,
		S_ADD,
		S_SUB,
		S_WALK,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		YS_IN,
		YS_INC,
		YS_DEC
	} year_src_t;

	typedef struct packed {
		logic      load_in;
		logic      leap_start;
		year_src_t leap_src;
		logic      leap_apply;
		logic      set_date;
		logic      add_step;
		logic      sub_step;
		logic      walk_init;
		logic      walk_step;
		logic      emit;
		logic      emit_cmp;
		logic      emit_xmas;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic year_end;
		logic year_start;
		logic walk_done;
		logic after_xmas;
		logic leap_busy;
	} sts_t;

	// Length of a month; codes outside 1..12 give 31.
	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] n;
		case (m) inside
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = LEN_SHORT;
			MONTH_FEB: n = leap ? LEN_FEB_L : LEN_FEB;
			default: n = LEN_LONG;
		endcase
		return n;
	endfunction

	function automatic logic [MONTH_W-1:0] clamp_month(logic [MONTH_W-1:0] m);
		logic [MONTH_W-1:0] r;
		if (m < MONTH_JAN) begin
			r = MONTH_JAN;
		end else if (m > MONTH_DEC) begin
			r = MONTH_DEC;
		end else begin
			r = m;
		end
		return r;
	endfunction

	function automatic logic [DAY_W-1:0] clamp_day(logic [DAY_W-1:0] d,
			logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] n;
		logic [DAY_W-1:0] r;
		n = month_len(m, leap);
		if (d > n) begin
			r = n;
		end else if (d < DAY_FIRST) begin
			r = DAY_FIRST;
		end else begin
			r = d;
		end
		return r;
	endfunction

	// Quotient of a year by 25.
	function automatic logic [QUOT_W-1:0] quot25(logic [YEAR_W-1:0] y);
		logic [PROD_W-1:0] p;
		p = PROD_W'(y) * DIV25_RECIP;
		return p[PROD_W-1 -: QUOT_W];
	endfunction

	// Leap rule: divisible by 4 and not a century, or a multiple of 400.
	// A century is divisible by 4 and 25, a multiple of 400 by 16 and 25.
	function automatic logic leap_rule(logic [YEAR_W-1:0] y, logic [QUOT_W-1:0] q);
		logic div25;
		logic century;
		logic quad_century;
		div25        = ((YEAR_W'(q) * DIV25) == y);
		century      = (y[1:0] == 2'b00) && div25;
		quad_century = (y[3:0] == 4'b0000) && div25;
		return ((y[1:0] == 2'b00) && !century) || quad_century;
	endfunction

endpackage

// ----- rtl/cdc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one operation item into the counter.
// ----------------------------------------------------------------------------
interface cdc_req_if
	import cdc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [DAY_W-1:0]    day_in;
	logic [MONTH_W-1:0]  month_in;
	logic [YEAR_W-1:0]   year_in;
	logic [COUNT_W-1:0]  day_count;

	modport source (
		output valid, opcode, day_in, month_in, year_in, day_count,
		input  ready
	);

	modport sink (
		input  valid, opcode, day_in, month_in, year_in, day_count,
		output ready
	);
endinterface

// ----- rtl/cdc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item out of the counter.
// ----------------------------------------------------------------------------
interface cdc_rsp_if
	import cdc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DAY_W-1:0]   day_out;
	logic [MONTH_W-1:0] month_out;
	logic [YEAR_W-1:0]  year_out;
	logic               is_later;
	logic [XDAYS_W-1:0] days_to_christmas;

	modport source (
		output valid, day_out, month_out, year_out, is_later, days_to_christmas,
		input  ready
	);

	modport sink (
		input  valid, day_out, month_out, year_out, is_later, days_to_christmas,
		output ready
	);
endinterface

// ----- rtl/cdc_leap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leap year unit
// Registers a 16-bit year, divides it by 25 with a reciprocal multiply into
// a quotient register, then derives the leap flag from the quotient.
// ----------------------------------------------------------------------------
module cdc_leap
	import cdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [YEAR_W-1:0] year,
	output logic              busy,
	output logic              leap
);

	logic [YEAR_W-1:0] year_q;
	logic [QUOT_W-1:0] quot_s1;
	logic              leap_q;
	logic [1:0]        stage_q;

	// Stage flags: the quotient is pending, then the leap flag is pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else if (start) begin
			stage_q <= 2'b01;
		end else begin
			stage_q <= {stage_q[0], 1'b0};
		end
	end

	// Year register, quotient by 25 and the resulting leap flag.
	always_ff @(posedge clk) begin
		if (start) begin
			year_q <= year;
		end
		if (stage_q[0]) begin
			quot_s1 <= quot25(year_q);
		end
		if (stage_q[1]) begin
			leap_q <= leap_rule(year_q, quot_s1);
		end
	end

	assign busy = |stage_q;
	assign leap = leap_q;

endmodule

// ----- rtl/cdc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter controller
// Sequences each item through leap lookups, day steps and the month walk,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module cdc_ctrl
	import cdc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [OPCODE_W-1:0] req_opcode,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output cmd_t                cmd,
	input  sts_t                sts
);

	state_t              state_q;
	state_t              state_d;
	logic [OPCODE_W-1:0] op_q;
	logic                rsp_valid_q;

	// State register and latched opcode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_SET;
		end else begin
			state_q <= state_d;
			if (req_valid && req_ready) begin
				op_q <= req_opcode;
			end
		end
	end

	// Output valid flag: set when a result is loaded, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					case (req_opcode)
						OP_SET, OP_CMP: state_d = S_LSTART;
						OP_ADD:         state_d = S_ADD;
						OP_SUB:         state_d = S_SUB;
						OP_XMAS: begin
							cmd.walk_init = 1'b1;
							state_d       = S_WALK;
						end
						default:        state_d = S_EMIT;
					endcase
				end
			end
			S_LSTART: begin
				cmd.leap_start = 1'b1;
				cmd.leap_src   = YS_IN;
				state_d        = S_LWAIT;
			end
			S_LWAIT: begin
				if (!sts.leap_busy) begin
					case (op_q)
						OP_SET: begin
							cmd.set_date = 1'b1;
							state_d      = S_EMIT;
						end
						OP_ADD: begin
							cmd.leap_apply = 1'b1;
							state_d        = S_ADD;
						end
						OP_SUB: begin
							cmd.leap_apply = 1'b1;
							state_d        = S_SUB;
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_ADD: begin
				if (sts.count_zero) begin
					state_d = S_EMIT;
				end else begin
					cmd.add_step = 1'b1;
					if (sts.year_end) begin
						cmd.leap_start = 1'b1;
						cmd.leap_src   = YS_INC;
						state_d        = S_LWAIT;
					end
				end
			end
			S_SUB: begin
				if (sts.count_zero) begin
					state_d = S_EMIT;
				end else begin
					cmd.sub_step = 1'b1;
					if (sts.year_start) begin
						cmd.leap_start = 1'b1;
						cmd.leap_src   = YS_DEC;
						state_d        = S_LWAIT;
					end
				end
			end
			S_WALK: begin
				if (sts.walk_done) begin
					if (sts.after_xmas) begin
						cmd.leap_start = 1'b1;
						cmd.leap_src   = YS_INC;
						state_d        = S_LWAIT;
					end else begin
						state_d = S_EMIT;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			S_EMIT: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.emit      = 1'b1;
					cmd.emit_cmp  = (op_q == OP_CMP);
					cmd.emit_xmas = (op_q == OP_XMAS);
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	// The leap unit is never restarted while it is still reducing a year.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.leap_start |-> !sts.leap_busy)
		else $error("leap unit restarted while busy");

	// A loaded result is presented in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> rsp_valid)
		else $error("result loaded but not presented");

	// Day steps only happen while days remain to be counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_step || cmd.sub_step) |-> !sts.count_zero)
		else $error("day step with an empty count");

endmodule

// ----- rtl/cdc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter datapath
// Holds the stored date, the day count, the month walk accumulator, the leap
// unit and the result register; acts on commands from the controller.
// ----------------------------------------------------------------------------
module cdc_dpath
	import cdc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [DAY_W-1:0]   day_in,
	input  logic [MONTH_W-1:0] month_in,
	input  logic [YEAR_W-1:0]  year_in,
	input  logic [COUNT_W-1:0] day_count,
	output logic [DAY_W-1:0]   day_out,
	output logic [MONTH_W-1:0] month_out,
	output logic [YEAR_W-1:0]  year_out,
	output logic               is_later,
	output logic [XDAYS_W-1:0] days_to_christmas
);

	localparam int unsigned EXT_W = COUNT_W + COUNT_BITS;

	// Stored date.
	logic [DAY_W-1:0]      cur_day_q;
	logic [MONTH_W-1:0]    cur_month_q;
	logic [YEAR_W-1:0]     cur_year_q;
	logic                  leap_q;

	// Latched item fields and work registers.
	logic [DAY_W-1:0]      day_in_q;
	logic [MONTH_W-1:0]    month_in_q;
	logic [YEAR_W-1:0]     year_in_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [MONTH_W-1:0]    walk_m_q;
	logic [DOY_W-1:0]      doy_q;

	// Result register.
	logic [DAY_W-1:0]      day_out_q;
	logic [MONTH_W-1:0]    month_out_q;
	logic [YEAR_W-1:0]     year_out_q;
	logic                  later_out_q;
	logic [XDAYS_W-1:0]    xdays_out_q;

	logic [EXT_W-1:0]      count_ext;
	logic [DAY_W-1:0]      dim;
	logic [DAY_W-1:0]      prev_len;
	logic [YEAR_W-1:0]     leap_req_year;
	logic                  unit_busy;
	logic                  unit_leap;
	logic [MONTH_W-1:0]    item_month;
	logic [DAY_W-1:0]      set_day;
	logic                  later;
	logic [DOY_W:0]        xmas_doy;
	logic [DOY_W:0]        xdays;

	// Only the low COUNT_BITS bits of the count are used.
	assign count_ext = {{COUNT_BITS{1'b0}}, day_count};

	assign dim      = month_len(cur_month_q, leap_q);
	assign prev_len = month_len(cur_month_q - 1'b1, leap_q);

	// Year fed to the leap unit.
	always_comb begin
		case (cmd.leap_src)
			YS_IN:   leap_req_year = year_in_q;
			YS_INC:  leap_req_year = cur_year_q + 1'b1;
			YS_DEC:  leap_req_year = cur_year_q - 1'b1;
			default: leap_req_year = year_in_q;
		endcase
	end

	cdc_leap u_leap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.leap_start),
		.year   (leap_req_year),
		.busy   (unit_busy),
		.leap   (unit_leap)
	);

	// Clamped date of the item, using the leap flag of its own year.
	assign item_month = clamp_month(month_in_q);
	assign set_day    = clamp_day(day_in_q, item_month, unit_leap);

	// Later test: year first, then month, then day.
	always_comb begin
		if (cur_year_q != year_in_q) begin
			later = (cur_year_q > year_in_q);
		end else if (cur_month_q != item_month) begin
			later = (cur_month_q > item_month);
		end else begin
			later = (cur_day_q > set_day);
		end
	end

	// Days to Christmas from the day of the year; past it the count runs
	// into the next year with that year's leap flag.
	assign xmas_doy = (DOY_W + 1)'(XMAS_DOY) + (DOY_W + 1)'(leap_q);
	always_comb begin
		if (sts.after_xmas) begin
			xdays = (DOY_W + 1)'(YEAR_DAYS) + (DOY_W + 1)'(leap_q) - {1'b0, doy_q}
				+ (DOY_W + 1)'(XMAS_DOY) + (DOY_W + 1)'(unit_leap);
		end else begin
			xdays = xmas_doy - {1'b0, doy_q};
		end
	end

	// Status to the controller.
	always_comb begin
		sts.count_zero = (count_q == '0);
		sts.year_end   = (cur_day_q >= dim) && (cur_month_q == MONTH_DEC);
		sts.year_start = (cur_day_q <= DAY_FIRST) && (cur_month_q == MONTH_JAN);
		sts.walk_done  = (walk_m_q >= cur_month_q);
		sts.after_xmas = ({1'b0, doy_q} > xmas_doy);
		sts.leap_busy  = unit_busy;
	end

	// Stored date: set, single day steps forward and back, leap update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= RST_DAY;
			cur_month_q <= RST_MONTH;
			cur_year_q  <= RST_YEAR;
			leap_q      <= RST_LEAP;
		end else if (cmd.set_date) begin
			cur_year_q  <= year_in_q;
			cur_month_q <= item_month;
			cur_day_q   <= set_day;
			leap_q      <= unit_leap;
		end else if (cmd.leap_apply) begin
			leap_q <= unit_leap;
		end else if (cmd.add_step) begin
			if (cur_day_q < dim) begin
				cur_day_q <= cur_day_q + 1'b1;
			end else begin
				cur_day_q <= DAY_FIRST;
				if (cur_month_q == MONTH_DEC) begin
					cur_month_q <= MONTH_JAN;
					cur_year_q  <= cur_year_q + 1'b1;
				end else begin
					cur_month_q <= cur_month_q + 1'b1;
				end
			end
		end else if (cmd.sub_step) begin
			if (cur_day_q > DAY_FIRST) begin
				cur_day_q <= cur_day_q - 1'b1;
			end else if (cur_month_q == MONTH_JAN) begin
				cur_month_q <= MONTH_DEC;
				cur_day_q   <= LEN_LONG;
				cur_year_q  <= cur_year_q - 1'b1;
			end else begin
				cur_month_q <= cur_month_q - 1'b1;
				cur_day_q   <= prev_len;
			end
		end
	end

	// Item fields, day count and month walk.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			day_in_q   <= day_in;
			month_in_q <= month_in;
			year_in_q  <= year_in;
			count_q    <= count_ext[COUNT_BITS-1:0];
		end else if (cmd.add_step || cmd.sub_step) begin
			count_q <= count_q - 1'b1;
		end
		if (cmd.walk_init) begin
			walk_m_q <= MONTH_JAN;
			doy_q    <= DOY_W'(cur_day_q);
		end else if (cmd.walk_step) begin
			walk_m_q <= walk_m_q + 1'b1;
			doy_q    <= doy_q + DOY_W'(month_len(walk_m_q, leap_q));
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			day_out_q   <= cur_day_q;
			month_out_q <= cur_month_q;
			year_out_q  <= cur_year_q;
			later_out_q <= cmd.emit_cmp && later;
			xdays_out_q <= cmd.emit_xmas ? xdays[XDAYS_W-1:0] : '0;
		end
	end

	assign day_out           = day_out_q;
	assign month_out         = month_out_q;
	assign year_out          = year_out_q;
	assign is_later          = later_out_q;
	assign days_to_christmas = xdays_out_q;

	// The stored month stays a real month.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_month_q >= MONTH_JAN) && (cur_month_q <= MONTH_DEC))
		else $error("stored month out of range");

	// The stored day stays within its month.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_day_q >= DAY_FIRST) && (cur_day_q <= dim))
		else $error("stored day out of range");

endmodule

// ----- rtl/calendar_date_counter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter
// Gregorian date register with set, add days, remove days, compare and
// days-to-Christmas operations.
// ----------------------------------------------------------------------------
// Usage:
// One request item on req carries an opcode and its operands; it yields
// exactly one response item on rsp with the date after the operation.
// Items are processed one at a time; req is ready only while the sequencer
// is idle. A finished response sits in an output register, so the next item
// is taken while the previous response still waits for rsp.ready.
// Steps per item, from acceptance to the response being loaded:
//   set, compare     leap lookup (year register, multiply by the
//                    reciprocal of 25, leap rule)
//   add, remove      one day per cycle through the datapath day stepper,
//                    held for a leap lookup at each year boundary crossed
//   christmas        month walk up to the stored month, then past 25
//                    December a leap lookup of the next year
//   unused opcodes   straight to the response
// Reset (arst_n low) loads 1 January 2000 and empties the output register.
// If the receiver stalls, the response holds and the counter stops once the
// next item has finished, until the response is taken.
// ----------------------------------------------------------------------------
module calendar_date_counter_unit
	import cdc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	cdc_req_if.sink   req,
	cdc_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	// Controller: sequencing and handshakes.
	cdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_opcode (req.opcode),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// Datapath: date state, counters, leap unit and result register.
	cdc_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.day_in            (req.day_in),
		.month_in          (req.month_in),
		.year_in           (req.year_in),
		.day_count         (req.day_count),
		.day_out           (rsp.day_out),
		.month_out         (rsp.month_out),
		.year_out          (rsp.year_out),
		.is_later          (rsp.is_later),
		.days_to_christmas (rsp.days_to_christmas)
	);

endmodule
